[rtl/tmph_pkg.sv]
`timescale 1ns / 1ps

package tmph_pkg;

   // Widths of the fields at the ports.
   localparam int SAMPLE_W = 12;
   localparam int OFFSET_W = 16;
   localparam int PH_W     = 17;

   // Samples are widened to this before the low ADC bits are taken.
   localparam int WIDE_W = 16;

   // The slope is 3.3 * 5.70 = 18.81, kept as 1881 / 100.
   localparam int SLOPE_NUM_W = 11;
   localparam logic [SLOPE_NUM_W-1:0] SLOPE_NUM = 11'd1881;
   localparam int SLOPE_DEN = 100;

   // The result is in units of 1/1024 pH.
   localparam int SCALE_SHIFT = 10;

   // The slope term never reaches 2^15, so the quotient has 15 bits.
   localparam int QUOT_W = 15;

   // Thresholds of 4.00 and 9.00 pH, in units of 1/1024 pH.
   localparam int PH_LOW_Q  = 4096;
   localparam int PH_HIGH_Q = 9216;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd21852;

endpackage

[rtl/trimmed_mean_ph_converter.sv]
`timescale 1ns / 1ps

// A request that does not complete a burst is taken as soon as it is offered; the one that
// completes it starts the calculation: each sample in turn is loaded, ranked and tallied,
// then the sum is multiplied, the quotient estimated, back-multiplied and corrected, and the
// response finished, which waits while the previous response is still stalled at the output.
// Requests stall from then until the response is registered. Synchronous reset empties the
// burst, clears the response and loads the default offset, not the sample store.
module trimmed_mean_ph_converter
   import tmph_pkg::*;
#(
   parameter int BURST_LENGTH = 10,
   parameter int TRIM_COUNT   = 2,
   parameter int ADC_BITS     = 12
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [SAMPLE_W-1:0]  req_adc_sample,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [PH_W-1:0] rsp_ph_value,
   output logic                 rsp_out_of_range,

   input  logic                 csr_write_enable,
   input  logic [OFFSET_W-1:0]  csr_write_data
);

   // Number of samples that survive the trim; zero when the trim swallows the burst.
   localparam int KEPT = (BURST_LENGTH > 2 * TRIM_COUNT) ? BURST_LENGTH - 2 * TRIM_COUNT : 0;

   // Position counters run from 0 to BURST_LENGTH - 1.
   localparam int CNT_W = $clog2(BURST_LENGTH);
   // The rank is compared against TRIM_COUNT + KEPT, which may exceed BURST_LENGTH - 1.
   localparam int RK_W  = $clog2(BURST_LENGTH + TRIM_COUNT + 1);

   // The trimmed sum holds at most BURST_LENGTH samples of ADC_BITS bits.
   localparam int SUM_W  = ADC_BITS + $clog2(BURST_LENGTH);
   localparam int PROD_W = SUM_W + SLOPE_NUM_W;
   localparam int NUM_W  = PROD_W + SCALE_SHIFT;

   // The slope term is num / DIVISOR with num = sum * 1881 * 1024.
   localparam longint unsigned DIVISOR =
      (KEPT > 0) ? longint'(SLOPE_DEN) * (longint'(1) << ADC_BITS) * longint'(KEPT) : 1;

   // Reciprocal of the divisor scaled by 2^(PROD_W + SCALE_SHIFT). Multiplying the product of
   // the sum and the slope by it undershoots the quotient by at most one, which one compare
   // and subtract puts right.
   localparam longint unsigned RECIP =
      (KEPT > 0) ? (longint'(1) << (PROD_W + SCALE_SHIFT)) / DIVISOR : 0;
   localparam int DIV_W   = $clog2(DIVISOR + 1);
   localparam int RECIP_W = $clog2(RECIP + 1);

   // Operand widths of the one shared multiplier.
   localparam int MUL_A_W  = PROD_W;
   localparam int MUL_B_W0 = (DIV_W > RECIP_W) ? DIV_W : RECIP_W;
   localparam int MUL_B_W  = (MUL_B_W0 > QUOT_W) ? MUL_B_W0 : QUOT_W;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

   localparam logic [MUL_B_W-1:0] SLOPE_B   = MUL_B_W'(SLOPE_NUM);
   localparam logic [MUL_B_W-1:0] RECIP_B   = MUL_B_W'(RECIP);
   localparam logic [MUL_B_W-1:0] DIVISOR_B = MUL_B_W'(DIVISOR);
   localparam logic [NUM_W-1:0]   DIVISOR_N = NUM_W'(DIVISOR);

   localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(BURST_LENGTH - 1);
   localparam logic [RK_W-1:0]  RANK_LO  = RK_W'(TRIM_COUNT);
   localparam logic [RK_W-1:0]  RANK_HI  = RK_W'(TRIM_COUNT + KEPT);

   localparam int CMP_W = PH_W + 1;

   // The sequencer. Each stored sample is ranked in turn: LOAD picks the sample at the head
   // of the ring, RANK turns the ring once round and counts the samples that sort before it,
   // and TALLY adds it to the sum when its rank lies in the kept window. MUL scales the sum,
   // ESTIMATE takes the quotient from the reciprocal, BACK forms the remainder from it and
   // CORRECT adds the one step that the estimate may fall short. FINISH builds the response.
   // MUL, ESTIMATE and BACK all use the same multiplier.
   typedef enum logic [3:0] {
      COLLECT,
      LOAD,
      RANK,
      TALLY,
      MUL,
      ESTIMATE,
      BACK,
      CORRECT,
      FINISH
   } state_type;

   state_type state_ff;

   // The sample store is a ring of registers that is only ever read at its head.
   logic [ADC_BITS-1:0] ring_ff [BURST_LENGTH];

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       pos_ff;
   logic [CNT_W-1:0]       head_ff;
   logic [CNT_W-1:0]       step_ff;
   logic [RK_W-1:0]        rank_ff;
   logic [ADC_BITS-1:0]    cand_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [NUM_W-1:0]       rem_ff;
   logic [QUOT_W-1:0]      quot_ff;
   logic [OFFSET_W-1:0]    offset_ff;

   logic                   rsp_valid_ff;
   logic signed [PH_W-1:0] rsp_ph_value_ff;
   logic                   rsp_out_of_range_ff;

   logic                   req_take;
   logic                   ring_turn;
   logic [ADC_BITS-1:0]    ring_tail;
   logic [WIDE_W-1:0]      sample_wide;
   logic [CNT_W-1:0]       head_next;
   logic                   sorts_before;
   logic [MUL_A_W-1:0]     mul_a;
   logic [MUL_B_W-1:0]     mul_b;
   logic [MUL_P_W-1:0]     mul_out;
   logic [PROD_W-1:0]      prod;
   logic                   round_up;
   logic [QUOT_W:0]        term;
   logic signed [CMP_W-1:0] off_ext;
   logic signed [CMP_W-1:0] quot_ext;
   logic signed [CMP_W-1:0] ph_full;
   logic signed [CMP_W-1:0] low_bound;
   logic signed [CMP_W-1:0] high_bound;
   logic signed [PH_W-1:0]  ph_sat;
   logic                    flag;
   logic                    rsp_free;

   assign req_stall        = (state_ff != COLLECT);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ph_value     = rsp_ph_value_ff;
   assign rsp_out_of_range = rsp_out_of_range_ff;

   assign req_take    = req_valid && (state_ff == COLLECT);
   assign sample_wide = WIDE_W'(req_adc_sample);

   // The ring shifts towards its head. While collecting, a new request enters at the tail;
   // while ranking, the head wraps round to the tail.
   assign ring_turn = req_take || (state_ff == RANK) || (state_ff == TALLY);
   assign ring_tail = (state_ff == COLLECT) ? sample_wide[ADC_BITS-1:0] : ring_ff[0];
   assign head_next = (head_ff == LAST_POS) ? '0 : head_ff + 1'b1;

   // Ties are broken by position in the ring, so every sample gets a distinct rank.
   assign sorts_before = (ring_ff[0] < cand_ff) || ((ring_ff[0] == cand_ff) && (head_ff < pos_ff));

   // The shared multiplier: sum times the slope numerator, then the scaled product times the
   // reciprocal, then the estimated quotient times the divisor.
   always_comb begin
      unique case (state_ff)
         ESTIMATE: begin
            mul_a = rem_ff[NUM_W-1:SCALE_SHIFT];
            mul_b = RECIP_B;
         end
         BACK: begin
            mul_a = MUL_A_W'(quot_ff);
            mul_b = DIVISOR_B;
         end
         default: begin
            mul_a = MUL_A_W'(sum_ff);
            mul_b = SLOPE_B;
         end
      endcase
   end

   assign mul_out = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
   assign prod    = mul_out[PROD_W-1:0];

   // Round to nearest with ties up: add one when twice the remainder reaches the divisor.
   assign round_up = ({rem_ff, 1'b0} >= (NUM_W + 1)'(DIVISOR));
   assign term     = {1'b0, quot_ff} + (QUOT_W + 1)'(round_up);

   assign off_ext  = CMP_W'($signed(offset_ff));
   assign quot_ext = $signed(CMP_W'(quot_ff));
   assign ph_full  = off_ext - $signed(CMP_W'(term));

   always_comb begin
      if (ph_full > $signed(CMP_W'((1 << (PH_W - 1)) - 1))) begin
         ph_sat = PH_W'((1 << (PH_W - 1)) - 1);
      end else if (ph_full < -$signed(CMP_W'(1 << (PH_W - 1)))) begin
         ph_sat = PH_W'(1 << (PH_W - 1));
      end else begin
         ph_sat = ph_full[PH_W-1:0];
      end
   end

   // The flag uses the exact quotient. With q the floor of the slope term and r its
   // remainder, pH <= 4.00 exactly when q >= offset - 4096, and pH >= 9.00 exactly when
   // q < offset - 9216, or q equals it with nothing left over.
   assign low_bound  = off_ext - $signed(CMP_W'(PH_LOW_Q));
   assign high_bound = off_ext - $signed(CMP_W'(PH_HIGH_Q));
   assign flag = (quot_ext >= low_bound) || (quot_ext < high_bound) ||
                 ((quot_ext == high_bound) && (rem_ff == '0));

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (ring_turn) begin
         for (int k = 0; k < BURST_LENGTH - 1; k++) begin
            ring_ff[k] <= ring_ff[k+1];
         end
         ring_ff[BURST_LENGTH-1] <= ring_tail;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= COLLECT;
         count_ff            <= '0;
         offset_ff           <= OFFSET_RESET;
         rsp_valid_ff        <= 1'b0;
         pos_ff              <= '0;
         head_ff             <= '0;
         step_ff             <= '0;
         rank_ff             <= '0;
      end else begin
         if (csr_write_enable) begin
            offset_ff <= csr_write_data;
         end

         // A new response may replace one that leaves in the same cycle.
         if ((state_ff == FINISH) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            COLLECT: begin
               if (req_take) begin
                  if (count_ff == LAST_POS) begin
                     count_ff <= '0;
                     pos_ff   <= '0;
                     head_ff  <= '0;
                     sum_ff   <= '0;
                     state_ff <= LOAD;
                  end else begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end

            LOAD: begin
               cand_ff  <= ring_ff[0];
               rank_ff  <= '0;
               step_ff  <= '0;
               state_ff <= RANK;
            end

            RANK: begin
               rank_ff <= rank_ff + RK_W'(sorts_before);
               head_ff <= head_next;
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_POS) begin
                  state_ff <= TALLY;
               end
            end

            TALLY: begin
               if ((rank_ff >= RANK_LO) && (rank_ff < RANK_HI)) begin
                  sum_ff <= sum_ff + SUM_W'(cand_ff);
               end
               head_ff <= head_next;
               if (pos_ff == LAST_POS) begin
                  state_ff <= MUL;
               end else begin
                  pos_ff   <= pos_ff + 1'b1;
                  state_ff <= LOAD;
               end
            end

            MUL: begin
               rem_ff   <= {prod, SCALE_SHIFT'(0)};
               state_ff <= ESTIMATE;
            end

            ESTIMATE: begin
               quot_ff  <= mul_out[PROD_W +: QUOT_W];
               state_ff <= BACK;
            end

            BACK: begin
               rem_ff   <= rem_ff - mul_out[NUM_W-1:0];
               state_ff <= CORRECT;
            end

            CORRECT: begin
               if (rem_ff >= DIVISOR_N) begin
                  quot_ff <= quot_ff + 1'b1;
                  rem_ff  <= rem_ff - DIVISOR_N;
               end
               state_ff <= FINISH;
            end

            FINISH: begin
               // Wait here until the response register is free.
               if (rsp_free) begin
                  rsp_ph_value_ff     <= ph_sat;
                  rsp_out_of_range_ff <= flag;
                  state_ff            <= COLLECT;
               end
            end

            default: begin
               state_ff <= COLLECT;
            end
         endcase
      end
   end

endmodule

[tb/ph_burst_checker.sv]
`timescale 1ns / 1ps

// Watches both channels and the calibration port, keeps its own copy of the burst store
// and the offset, and checks each response against the oldest awaited pH result.
module ph_burst_checker
   import tmph_pkg::*;
#(
   parameter int BURST_LENGTH = 10,
   parameter int TRIM_COUNT   = 2,
   parameter int ADC_BITS     = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [SAMPLE_W-1:0]    req_adc_sample,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic signed [PH_W-1:0] rsp_ph_value,
   input  logic                   rsp_out_of_range,
   input  logic                   csr_write_enable,
   input  logic [OFFSET_W-1:0]    csr_write_data,
   output int                     fails,
   output int                     awaited,
   output int                     checked,
   output int                     flagged
);

   localparam int KEPT = BURST_LENGTH - 2 * TRIM_COUNT;
   localparam longint DIVISOR =
      (KEPT > 0) ? longint'(SLOPE_DEN) * (longint'(1) << ADC_BITS) * KEPT : 1;

   typedef logic [ADC_BITS-1:0] sample_set_type [BURST_LENGTH];

   typedef struct {
      logic signed [PH_W-1:0] ph;
      logic                   flag;
   } ph_result_type;

   sample_set_type           burst_samples;
   int                       burst_fill = 0;
   logic signed [OFFSET_W-1:0] cal_offset = OFFSET_RESET;
   ph_result_type            ph_awaited [$];
   int                       error_total = 0;
   int                       result_total = 0;
   int                       flag_total = 0;

   // Sorts the burst, sums the middle samples and converts the sum to pH in 1/1024 units, with its range flag.
   function automatic ph_result_type burst_ph(input sample_set_type raw,
                                              input logic signed [OFFSET_W-1:0] off);
      sample_set_type  ranked;
      logic [ADC_BITS-1:0] key;
      longint          total;
      longint          scaled;
      longint          term;
      longint          base;
      longint          ph;
      int              j;
      ph_result_type   res;
      ranked = raw;
      for (int i = 1; i < BURST_LENGTH; i++) begin
         key = ranked[i];
         j = i - 1;
         while (j >= 0 && ranked[j] > key) begin
            ranked[j + 1] = ranked[j];
            j--;
         end
         ranked[j + 1] = key;
      end
      total = 0;
      scaled = 0;
      term = 0;
      if (KEPT > 0) begin
         for (int i = TRIM_COUNT; i < TRIM_COUNT + KEPT; i++) begin
            total += ranked[i];
         end
         scaled = (total * SLOPE_NUM) << SCALE_SHIFT;
         term = (scaled + DIVISOR / 2) / DIVISOR;
      end
      base = off;
      ph = base - term;
      if (ph > 65535) ph = 65535;
      if (ph < -65536) ph = -65536;
      res.ph = ph[PH_W-1:0];
      // The flag uses the exact quotient, not the rounded one.
      res.flag = ((base - PH_LOW_Q) * DIVISOR <= scaled) ||
                 (scaled <= (base - PH_HIGH_Q) * DIVISOR);
      return res;
   endfunction

   always @(posedge clock) begin
      ph_result_type want;
      if (reset) begin
         burst_fill = 0;
         cal_offset = OFFSET_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (ph_awaited.size() == 0) begin
               $display("%0t: response with no request awaiting, got ph %0d flag %0b",
                        $time, rsp_ph_value, rsp_out_of_range);
               error_total++;
            end else begin
               want = ph_awaited.pop_front();
               if (rsp_ph_value !== want.ph) begin
                  $display("%0t: ph_value expected %0d, got %0d",
                           $time, want.ph, rsp_ph_value);
                  error_total++;
               end
               if (rsp_out_of_range !== want.flag) begin
                  $display("%0t: out_of_range expected %0b, got %0b",
                           $time, want.flag, rsp_out_of_range);
                  error_total++;
               end
               result_total++;
               if (want.flag) flag_total++;
            end
         end
         if (csr_write_enable) cal_offset = csr_write_data;
         if (req_valid && !req_stall) begin
            burst_samples[burst_fill] = ADC_BITS'(req_adc_sample);
            burst_fill++;
            if (burst_fill == BURST_LENGTH) begin
               burst_fill = 0;
               ph_awaited.push_back(burst_ph(burst_samples, cal_offset));
            end
         end
      end
      fails   <= error_total;
      awaited <= ph_awaited.size();
      checked <= result_total;
      flagged <= flag_total;
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

// Top of the pH converter bench. It makes the sample stream, the calibration writes and the
// response back-pressure, and gives the verdict; all prediction and comparison is done by
// the checker instantiated beside the converter.
module tb_top
   import tmph_pkg::*;
();

   localparam int BURST_LENGTH = 10;
   localparam int TRIM_COUNT   = 2;
   localparam int ADC_BITS     = 12;
   localparam int MAX_SAMPLE   = (1 << ADC_BITS) - 1;

   // Allowance for the calculation that follows the request that completes a burst.
   localparam int CALC_CYCLES  = BURST_LENGTH * (BURST_LENGTH + 2) + 5;
   localparam int SETTLE_CYCLES = CALC_CYCLES + 3;

   localparam int NUM_SETTINGS       = 12;
   localparam int BURSTS_PER_SETTING = 15;
   localparam int LONG_HOLD          = 3000;
   localparam int IDLE_LIMIT         = 20000;

   // How the samples of one random burst are spread.
   typedef enum int {
      SHAPE_WIDE,
      SHAPE_CLUSTER,
      SHAPE_TWO_LEVEL,
      SHAPE_FLAT
   } burst_shape_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [SAMPLE_W-1:0]    req_adc_sample;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic signed [PH_W-1:0] rsp_ph_value;
   logic                   rsp_out_of_range;
   logic                   csr_write_enable;
   logic [OFFSET_W-1:0]    csr_write_data;

   int fails;
   int awaited;
   int checked;
   int flagged;
   int burst_left;
   int samples_sent;
   int idle_cycles;

   // Calibration offsets in 1/1024 pH. The threshold values and their neighbours sit first,
   // since each setting opens with a burst of zero samples whose pH equals the offset
   // exactly. The last two entries are filled at random.
   int cal_settings [NUM_SETTINGS] = '{4096, 4097, 9215, 9216, -32768, 32767, 0,
                                       12000, 15000, 21852, 0, 0};

   // A burst whose six middle samples sum to 400. The slope term then lands exactly halfway
   // between two integers, so the rounding of ties is exercised. It also carries the lowest
   // and the highest sample values as the trimmed outliers.
   logic [SAMPLE_W-1:0] tie_burst [BURST_LENGTH] = '{12'd0, 12'd4095, 12'd66, 12'd67, 12'd66,
                                                     12'd67, 12'd0, 12'd67, 12'd4095, 12'd67};

   trimmed_mean_ph_converter #(
      .BURST_LENGTH (BURST_LENGTH),
      .TRIM_COUNT   (TRIM_COUNT),
      .ADC_BITS     (ADC_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_adc_sample   (req_adc_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ph_value     (rsp_ph_value),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   ph_burst_checker #(
      .BURST_LENGTH (BURST_LENGTH),
      .TRIM_COUNT   (TRIM_COUNT),
      .ADC_BITS     (ADC_BITS)
   ) scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_adc_sample   (req_adc_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ph_value     (rsp_ph_value),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fails            (fails),
      .awaited          (awaited),
      .checked          (checked),
      .flagged          (flagged)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offers one sample and returns just after the edge at which it was accepted. Requests
   // come in bursts of random length; between bursts valid is dropped for a random gap,
   // now and then long enough to outlast a whole calculation.
   task automatic offer(input logic [SAMPLE_W-1:0] sample);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(20, 200)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_adc_sample <= sample;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
   endtask

   // Stops offering requests until every awaited result has come back, then lets the
   // converter run out its calculation latency so that it is idle for a register write.
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Stimulus.
   initial begin
      int shape;
      int base;
      int alt;
      int spread;
      int v;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_adc_sample   = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      burst_left       = 0;
      samples_sent     = 0;
      cal_settings[10] = int'($urandom_range(0, 65535)) - 32768;
      cal_settings[11] = int'($urandom_range(0, 65535)) - 32768;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed bursts under the offset loaded by reset: every sample at full scale, then
      // the rounding tie with outliers at both ends.
      for (int i = 0; i < BURST_LENGTH; i++) begin
         offer(MAX_SAMPLE[SAMPLE_W-1:0]);
      end
      foreach (tie_burst[i]) begin
         offer(tie_burst[i]);
      end

      for (int p = 0; p < NUM_SETTINGS; p++) begin
         settle();
         csr_write_enable <= 1'b1;
         csr_write_data   <= OFFSET_W'(cal_settings[p]);
         @(posedge clock);
         csr_write_enable <= 1'b0;

         // An all-zero burst gives a slope term of zero, so the pH is the offset itself.
         for (int i = 0; i < BURST_LENGTH; i++) begin
            offer('0);
         end

         for (int b = 0; b < BURSTS_PER_SETTING; b++) begin
            shape  = $urandom_range(SHAPE_WIDE, SHAPE_FLAT);
            base   = $urandom_range(0, MAX_SAMPLE);
            alt    = $urandom_range(0, MAX_SAMPLE);
            spread = $urandom_range(0, 48);
            for (int i = 0; i < BURST_LENGTH; i++) begin
               case (burst_shape_type'(shape))
                  SHAPE_WIDE: begin
                     v = $urandom_range(0, MAX_SAMPLE);
                  end
                  SHAPE_CLUSTER: begin
                     // Mostly close together, with the odd outlier for the trim to drop.
                     if ($urandom_range(0, 9) == 0) begin
                        v = $urandom_range(0, 1) ? MAX_SAMPLE : 0;
                     end else begin
                        v = base + int'($urandom_range(0, 2 * spread)) - spread;
                     end
                  end
                  SHAPE_TWO_LEVEL: begin
                     v = $urandom_range(0, 1) ? base : alt;
                  end
                  default: begin
                     v = base;
                  end
               endcase
               if (v < 0) begin
                  v = 0;
               end else if (v > MAX_SAMPLE) begin
                  v = MAX_SAMPLE;
               end
               offer(v[SAMPLE_W-1:0]);
            end
         end
      end

      settle();
      $display("Run covered %0d samples under %0d calibration offsets plus the reset value.",
               samples_sent, NUM_SETTINGS);
      $display("%0d burst results were checked, %0d of them flagged out of range.",
               checked, flagged);
      if (fails == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Response back-pressure. The receiver switches between modes of random length: no
   // stalls, light, half and heavy stalling. Once, after a few results have come back, it
   // holds off for a long stretch while the sender keeps offering, so that the converter
   // fills up and has to stall its requests.
   initial begin
      int  mode;
      int  left;
      bit  held;
      logic stall_next;
      rsp_stall = 1'b0;
      mode = 0;
      left = 0;
      held = 1'b0;
      @(posedge clock);
      forever begin
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(5, 80);
         end
         left--;
         case (mode)
            0:       stall_next = 1'b0;
            1:       stall_next = ($urandom_range(0, 3) == 0);
            2:       stall_next = $urandom_range(0, 1);
            default: stall_next = ($urandom_range(0, 7) != 0);
         endcase
         if (!held && checked >= 25) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_stall <= stall_next;
            @(posedge clock);
         end
      end
   end

   // Watchdog: the run is abandoned if neither channel moves a request or a response for
   // far longer than the long hold-off plus a calculation would ever take.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog expired after %0d cycles without progress.", IDLE_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

endmodule
